[sv/gqlay_pkg.sv]
package gqlay_pkg;

    localparam int GLYPH_SLOTS = 128;
    localparam int SLOT_W      = $clog2(GLYPH_SLOTS);
    localparam int CNT_W       = $clog2(GLYPH_SLOTS + 1);

    // operation codes
    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_RECT    = 3'd1;
    localparam logic [2:0] OP_METRICS = 3'd2;
    localparam logic [2:0] OP_BEGIN   = 3'd3;
    localparam logic [2:0] OP_CHAR    = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_ATLAS_H = 2'd0;
    localparam logic [1:0] CFG_INV_W   = 2'd1;
    localparam logic [1:0] CFG_INV_H   = 2'd2;

    typedef struct packed {
        logic [11:0] left;
        logic [11:0] bottom;
        logic [11:0] width;
        logic [11:0] height;
    } t_rect;

    typedef struct packed {
        logic signed [15:0] bear_x;
        logic signed [15:0] bear_y;
        logic [14:0]        ext_w;
        logic [14:0]        ext_h;
        logic [14:0]        adv;
    } t_meta;

    // controller -> datapath
    typedef struct packed {
        logic       accept;    // input transaction taken this cycle
        logic       scan;      // table search in progress
        logic       mul_en;    // texture multiply step
        logic [1:0] mul_sel;   // 0 uL, 1 uR, 2 vA, 3 vB
        logic       cvt_en;    // round and clamp previous product
        logic [1:0] cvt_sel;
        logic       tpos;      // latch quad origin
        logic       emit;      // drive one vertex
        logic [1:0] emit_k;    // corner number
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic miss;
    } t_sts;

endpackage

[sv/gqlay_ctrl.sv]
module gqlay_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [2:0]        i_operation,
    input  gqlay_pkg::t_sts   i_sts,
    output gqlay_pkg::t_cmd   o_cmd,
    output logic              busy
);
    import gqlay_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_MUL  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (accept && i_operation == OP_CHAR) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cnt = '0;
                if (i_sts.hit) begin
                    n_state = S_MUL;
                end else if (i_sts.miss) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                if (r_cnt == 3'd4) begin
                    n_state = S_EMIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_EMIT: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.accept  = accept;
        o_cmd.scan    = (r_state == S_SCAN);
        o_cmd.mul_en  = (r_state == S_MUL) && (r_cnt != 3'd4);
        o_cmd.mul_sel = r_cnt[1:0];
        o_cmd.cvt_en  = (r_state == S_MUL) && (r_cnt != 3'd0);
        o_cmd.cvt_sel = 2'(r_cnt - 3'd1);
        o_cmd.tpos    = (r_state == S_MUL) && (r_cnt == 3'd0);
        o_cmd.emit    = (r_state == S_EMIT);
        o_cmd.emit_k  = r_cnt[1:0];
    end

    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_cnt == 3'd3) |=> (r_state == S_IDLE))
        else $error("emit did not end after four vertices");
    a_mul_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt <= 3'd4))
        else $error("multiply step out of range");
    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_SCAN) |-> $past(accept && i_operation == OP_CHAR))
        else $error("search started without a character");

endmodule

[sv/gqlay_dp.sv]
module gqlay_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gqlay_pkg::t_cmd     i_cmd,
    output gqlay_pkg::t_sts     o_sts,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [24:0]         i_cfg_data,
    input  logic [2:0]          i_operation,
    input  logic [20:0]         i_code,
    input  logic [11:0]         i_rect_left,
    input  logic [11:0]         i_rect_bottom,
    input  logic [11:0]         i_rect_width,
    input  logic [11:0]         i_rect_height,
    input  logic signed [15:0]  i_offset_x,
    input  logic signed [15:0]  i_offset_y,
    input  logic [14:0]         i_extent_w,
    input  logic [14:0]         i_extent_h,
    input  logic [14:0]         i_advance,
    output logic                o_valid,
    output logic signed [23:0]  o_pos_x,
    output logic signed [23:0]  o_pos_y,
    output logic [15:0]         o_tex_u,
    output logic [15:0]         o_tex_v,
    output logic [15:0]         o_vertex_number,
    output logic [1:0]          o_corner,
    output logic                o_last
);
    import gqlay_pkg::*;

    // glyph table
    logic [20:0] code_mem [GLYPH_SLOTS];
    t_rect       rect_mem [GLYPH_SLOTS];
    t_meta       meta_mem [GLYPH_SLOTS];

    logic [12:0] r_atlas_h;
    logic [24:0] r_inv_w, r_inv_h;
    logic [CNT_W-1:0]  r_loaded;
    logic [23:0] r_pen_x, r_pen_y;
    logic [15:0] r_vc;

    logic [20:0] r_code, r_code_rd;
    t_rect       r_rect_rd;
    t_meta       r_meta_rd;
    logic [CNT_W-1:0]  r_idx;
    logic [SLOT_W-1:0] r_rd_idx;
    logic        r_rd_vld;
    logic        hit, advance;

    logic signed [40:0] r_prod;
    logic [15:0] r_u0, r_u1, r_v0, r_v1;
    logic [23:0] r_tx, r_ty;

    logic signed [14:0] ah, mul_a;
    logic signed [25:0] mul_b;
    logic signed [40:0] rnd;
    logic [15:0] q16;
    logic [23:0] x1, y1;
    logic        xr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_h <= 13'd1024;
            r_inv_w   <= 25'd16384;
            r_inv_h   <= 25'd16384;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ATLAS_H: r_atlas_h <= i_cfg_data[12:0];
                CFG_INV_W:   r_inv_w   <= i_cfg_data;
                CFG_INV_H:   r_inv_h   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_operation == OP_RECT && r_loaded < CNT_W'(GLYPH_SLOTS)) begin
            code_mem[r_loaded[SLOT_W-1:0]] <= i_code;
            rect_mem[r_loaded[SLOT_W-1:0]] <= '{i_rect_left, i_rect_bottom,
                                                i_rect_width, i_rect_height};
            meta_mem[r_loaded[SLOT_W-1:0]] <= '0;
        end else if (i_cmd.accept && i_operation == OP_METRICS && r_loaded != '0) begin
            meta_mem[SLOT_W'(r_loaded - CNT_W'(1))] <= '{i_offset_x, i_offset_y,
                                                        i_extent_w, i_extent_h, i_advance};
        end
    end

    // table reads, one entry a cycle while searching
    assign hit     = r_rd_vld && (r_code_rd == r_code);
    assign advance = i_cmd.scan && !hit;
    assign o_sts.hit  = i_cmd.scan && hit;
    assign o_sts.miss = i_cmd.scan && !r_rd_vld && (r_idx >= r_loaded);

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_code_rd <= code_mem[r_idx[SLOT_W-1:0]];
            r_rect_rd <= rect_mem[r_idx[SLOT_W-1:0]];
            r_meta_rd <= meta_mem[r_idx[SLOT_W-1:0]];
            r_rd_idx  <= r_idx[SLOT_W-1:0];
        end
        if (i_cmd.accept) begin
            r_code <= i_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_idx <= '0;
            end else if (advance && r_idx < r_loaded) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (!i_cmd.scan) begin
                r_rd_vld <= 1'b0;
            end else if (!hit) begin
                r_rd_vld <= (r_idx < r_loaded);
            end
        end
    end

    // texture coordinate multiplier, one product a cycle
    assign ah = 15'($signed({2'b00, r_atlas_h})) - 15'($signed({3'b000, r_rect_rd.bottom}));
    always_comb begin
        case (i_cmd.mul_sel)
            2'd0:    mul_a = 15'($signed({3'b000, r_rect_rd.left}));
            2'd1:    mul_a = 15'($signed({2'b00, 13'(r_rect_rd.left) + 13'(r_rect_rd.width)}));
            2'd2:    mul_a = ah - 15'($signed({3'b000, r_rect_rd.height}));
            default: mul_a = ah;
        endcase
        mul_b = i_cmd.mul_sel[1] ? $signed({1'b0, r_inv_h}) : $signed({1'b0, r_inv_w});
    end

    // round to 16 fraction bits and clamp
    assign rnd = (r_prod + 41'sd128) >>> 8;
    always_comb begin
        if (r_prod <= 0) begin
            q16 = '0;
        end else if (rnd > 41'sd65535) begin
            q16 = 16'hFFFF;
        end else begin
            q16 = rnd[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.cvt_en) begin
            case (i_cmd.cvt_sel)
                2'd0:    r_u0 <= q16;
                2'd1:    r_u1 <= q16;
                2'd2:    r_v0 <= q16;
                default: r_v1 <= q16;
            endcase
        end
        if (i_cmd.tpos) begin
            r_tx <= r_pen_x + 24'($signed(r_meta_rd.bear_x));
            r_ty <= r_pen_y + 24'($signed(r_meta_rd.bear_y));
        end
    end

    // vertex output
    assign x1 = r_tx + {9'd0, r_meta_rd.ext_w};
    assign y1 = r_ty - {9'd0, r_meta_rd.ext_h};
    assign xr = (i_cmd.emit_k == 2'd1) || (i_cmd.emit_k == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_pos_x         <= xr ? x1 : r_tx;
            o_pos_y         <= i_cmd.emit_k[1] ? y1 : r_ty;
            o_tex_u         <= xr ? r_u1 : r_u0;
            o_tex_v         <= i_cmd.emit_k[1] ? r_v1 : r_v0;
            o_vertex_number <= r_vc + {14'd0, i_cmd.emit_k};
            o_corner        <= i_cmd.emit_k;
            o_last          <= (i_cmd.emit_k == 2'd3);
        end
    end

    // control state: fill count, pen, vertex counter, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_pen_x  <= '0;
            r_pen_y  <= '0;
            r_vc     <= '0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
            if (i_cmd.accept) begin
                case (i_operation)
                    OP_CLEAR: r_loaded <= '0;
                    OP_RECT: begin
                        if (r_loaded < CNT_W'(GLYPH_SLOTS)) begin
                            r_loaded <= r_loaded + CNT_W'(1);
                        end
                    end
                    OP_BEGIN: begin
                        r_pen_x <= 24'(i_offset_x);
                        r_pen_y <= 24'(i_offset_y);
                        r_vc    <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.emit && i_cmd.emit_k == 2'd3) begin
                r_pen_x <= r_pen_x + {9'd0, r_meta_rd.adv};
                r_vc    <= r_vc + 16'd4;
            end
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= CNT_W'(GLYPH_SLOTS))
        else $error("fill count beyond table size");
    a_corner_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_corner != 2'd0) |-> ($past(o_valid)
            && o_corner == 2'($past(o_corner) + 2'd1)))
        else $error("vertex corners out of sequence");
    a_hit_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.hit |-> ({1'b0, r_rd_idx} < r_loaded))
        else $error("match outside loaded slots");

endmodule

[sv/glyph_quad_layout_top.sv]
// Text quad generator: glyph table load operations and character layout.
// Table, clear, begin and unknown operations are taken at once; busy stays low for them.
// A matched character holds busy from acceptance through the search, multiply and emit steps:
// one slot a cycle through the code read port, one shared multiplier for the four texture
// products, then four vertices; o_valid pulses once per vertex, the receiver cannot stall.
// A character with no match drops busy once every loaded slot is searched. Synchronous active-low reset.
module glyph_quad_layout_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_operation,
    input  logic [20:0]         i_code,
    input  logic [11:0]         i_rect_left,
    input  logic [11:0]         i_rect_bottom,
    input  logic [11:0]         i_rect_width,
    input  logic [11:0]         i_rect_height,
    input  logic signed [15:0]  i_offset_x,
    input  logic signed [15:0]  i_offset_y,
    input  logic [14:0]         i_extent_w,
    input  logic [14:0]         i_extent_h,
    input  logic [14:0]         i_advance,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [24:0]         i_cfg_data,
    output logic                o_valid,
    output logic signed [23:0]  o_pos_x,
    output logic signed [23:0]  o_pos_y,
    output logic [15:0]         o_tex_u,
    output logic [15:0]         o_tex_v,
    output logic [15:0]         o_vertex_number,
    output logic [1:0]          o_corner,
    output logic                o_last
);
    import gqlay_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    gqlay_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .busy        (busy)
    );

    gqlay_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_operation     (i_operation),
        .i_code          (i_code),
        .i_rect_left     (i_rect_left),
        .i_rect_bottom   (i_rect_bottom),
        .i_rect_width    (i_rect_width),
        .i_rect_height   (i_rect_height),
        .i_offset_x      (i_offset_x),
        .i_offset_y      (i_offset_y),
        .i_extent_w      (i_extent_w),
        .i_extent_h      (i_extent_h),
        .i_advance       (i_advance),
        .o_valid         (o_valid),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_tex_u         (o_tex_u),
        .o_tex_v         (o_tex_v),
        .o_vertex_number (o_vertex_number),
        .o_corner        (o_corner),
        .o_last          (o_last)
    );

endmodule
